FILE: rtl/bosa_pkg.sv
package bosa_pkg;

   // Default coordinate width: signed Q12.4
   localparam int COORD_WIDTH_DEF = 16;
   // Coordinates per box: four corners, x before y
   localparam int NUM_COORDS      = 8;
   localparam int NUM_CORNERS     = 4;
   // Candidate separating axes: edges p1-p2 and p2-p3 of each box
   localparam int NUM_AXES        = 4;
   // Registered stages inside one axis lane
   localparam int LANE_STAGES     = 5;
   localparam int RSP_TDATA_W     = 8;

   typedef enum logic {
      FUNC_LOAD = 1'b0,
      FUNC_TEST = 1'b1
   } func_type;

   // Front end control: reference box write and stage-0 capture
   typedef struct packed {
      logic load_en;
      logic capture_en;
   } front_ctl_type;

   // Per-stage advance strobes of an axis lane
   typedef struct packed {
      logic prod_en;
      logic proj_en;
      logic pair_en;
      logic span_en;
      logic hit_en;
   } lane_ctl_type;

endpackage

FILE: rtl/box_overlap_separating_axis.sv
// Separating axis overlap engine for 2D oriented boxes.
//
// Input channel req_*: one transfer carries the four corners of a quad in
// req_tdata and the function in req_tuser. A load transfer stores the quad
// as the reference box and produces no response. A test transfer checks the
// quad against the reference box as it stood when the transfer was taken.
// Output channel rsp_*: one transfer per test, bit 0 of rsp_tdata = overlap.
//
// Four axis lanes (edges p1-p2, p2-p3 of each box) project all eight corners
// with exact dot products in parallel; a merge stage ANDs the lane results.
// Each test passes capture, multiply, add, two min/max levels, interval
// compare and the output register, in that order, before rsp_tvalid rises.
// Throughput: one transfer per cycle of either kind unless a receiver stall
// has filled the pipeline, set by the fully pipelined lanes.
//
// Reset clears the reference box to all corners at the origin and empties the
// pipeline. When the receiver stalls, each stage holds while its successor is
// full; bubbles close up, and req_tready drops only once all seven stages
// hold tests.
module box_overlap_separating_axis #(
   parameter int COORD_WIDTH = bosa_pkg::COORD_WIDTH_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   // corner1_x, corner1_y, ... corner4_x, corner4_y, COORD_WIDTH bits each
   input  logic [bosa_pkg::NUM_COORDS*COORD_WIDTH-1:0]   req_tdata,
   // func
   input  logic [0:0]                                    req_tuser,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   // overlap, then zero fill
   output logic [bosa_pkg::RSP_TDATA_W-1:0]              rsp_tdata
);
   import bosa_pkg::*;

   // Stage 0 is the front capture, stages 1..LANE_STAGES sit in the lanes
   localparam int NS = LANE_STAGES + 1;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS:0]   stage_en;      // top bit advances the output register
   logic          req_xfer;
   func_type      req_func;

   front_ctl_type front_ctl;
   lane_ctl_type  lane_ctl;

   logic signed [COORD_WIDTH-1:0] ref_box  [NUM_COORDS];
   logic signed [COORD_WIDTH-1:0] test_box [NUM_COORDS];
   logic signed [COORD_WIDTH:0]   axis_x   [NUM_AXES];
   logic signed [COORD_WIDTH:0]   axis_y   [NUM_AXES];
   logic                          lane_hit [NUM_AXES];

   assign req_func = func_type'(req_tuser[0]);
   assign req_xfer = req_tvalid && req_tready;

   // A stage advances when it is empty or its successor advances
   always_comb begin
      stage_en[NS] = !rsp_tvalid || rsp_tready;
      for (int k = NS - 1; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   assign req_tready = stage_en[0];

   // Only tests enter the pipeline; loads end at the reference store
   always_comb begin
      valid_in    = valid_ff;
      if (stage_en[0]) begin
         valid_in[0] = req_xfer && (req_func == FUNC_TEST);
      end
      for (int k = 1; k < NS; k++) begin
         if (stage_en[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      front_ctl.load_en    = req_xfer && (req_func == FUNC_LOAD);
      front_ctl.capture_en = stage_en[0];
      lane_ctl.prod_en     = stage_en[1];
      lane_ctl.proj_en     = stage_en[2];
      lane_ctl.pair_en     = stage_en[3];
      lane_ctl.span_en     = stage_en[4];
      lane_ctl.hit_en      = stage_en[5];
   end

   bosa_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .ctl      (front_ctl),
      .corners  (req_tdata),
      .ref_box  (ref_box),
      .test_box (test_box),
      .axis_x   (axis_x),
      .axis_y   (axis_y)
   );

   for (genvar j = 0; j < NUM_AXES; j++) begin : g_lane
      bosa_lane #(
         .COORD_WIDTH (COORD_WIDTH)
      ) u_lane (
         .clock    (clock),
         .ctl      (lane_ctl),
         .ref_box  (ref_box),
         .test_box (test_box),
         .axis_x   (axis_x[j]),
         .axis_y   (axis_y[j]),
         .lane_hit (lane_hit[j])
      );
   end

   bosa_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .hit_valid  (valid_ff[NS-1]),
      .lane_hit   (lane_hit),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // A load never enters the pipeline
   a_load_no_entry: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_func == FUNC_LOAD) |=> !valid_ff[0])
      else $error("load transfer entered the pipeline");

   // A test always enters stage 0
   a_test_entry: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_func == FUNC_TEST) |=> valid_ff[0])
      else $error("test transfer lost at capture");

   // The last lane stage holds its item while the output is blocked
   a_tail_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff[NS-1] && !stage_en[NS] |=> valid_ff[NS-1])
      else $error("lane result dropped under stall");

   // Input is refused only when every stage is occupied
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (&valid_ff) && rsp_tvalid && !rsp_tready)
      else $error("input stalled with room in the pipeline");

endmodule

FILE: rtl/bosa_front.sv
module bosa_front #(
   parameter int COORD_WIDTH = bosa_pkg::COORD_WIDTH_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  bosa_pkg::front_ctl_type                       ctl,
   input  logic [bosa_pkg::NUM_COORDS*COORD_WIDTH-1:0]   corners,
   output logic signed [COORD_WIDTH-1:0]                 ref_box  [bosa_pkg::NUM_COORDS],
   output logic signed [COORD_WIDTH-1:0]                 test_box [bosa_pkg::NUM_COORDS],
   output logic signed [COORD_WIDTH:0]                   axis_x   [bosa_pkg::NUM_AXES],
   output logic signed [COORD_WIDTH:0]                   axis_y   [bosa_pkg::NUM_AXES]
);
   import bosa_pkg::*;

   localparam int AW = COORD_WIDTH + 1;

   logic signed [COORD_WIDTH-1:0] ref_corner_ff [NUM_COORDS];
   logic signed [COORD_WIDTH-1:0] in_corner     [NUM_COORDS];
   logic signed [COORD_WIDTH-1:0] ref_box_ff    [NUM_COORDS];
   logic signed [COORD_WIDTH-1:0] test_box_ff   [NUM_COORDS];
   logic signed [AW-1:0]          axis_x_in     [NUM_AXES];
   logic signed [AW-1:0]          axis_y_in     [NUM_AXES];
   logic signed [AW-1:0]          axis_x_ff     [NUM_AXES];
   logic signed [AW-1:0]          axis_y_ff     [NUM_AXES];

   always_comb begin
      for (int k = 0; k < NUM_COORDS; k++) begin
         in_corner[k] = $signed(corners[k*COORD_WIDTH +: COORD_WIDTH]);
      end
   end

   // Edge axes p1-p2 and p2-p3, first of the stored box, then of the incoming quad
   always_comb begin
      axis_x_in[0] = AW'(ref_corner_ff[0]) - AW'(ref_corner_ff[2]);
      axis_y_in[0] = AW'(ref_corner_ff[1]) - AW'(ref_corner_ff[3]);
      axis_x_in[1] = AW'(ref_corner_ff[2]) - AW'(ref_corner_ff[4]);
      axis_y_in[1] = AW'(ref_corner_ff[3]) - AW'(ref_corner_ff[5]);
      axis_x_in[2] = AW'(in_corner[0]) - AW'(in_corner[2]);
      axis_y_in[2] = AW'(in_corner[1]) - AW'(in_corner[3]);
      axis_x_in[3] = AW'(in_corner[2]) - AW'(in_corner[4]);
      axis_y_in[3] = AW'(in_corner[3]) - AW'(in_corner[5]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_COORDS; k++) begin
            ref_corner_ff[k] <= '0;
         end
      end else if (ctl.load_en) begin
         for (int k = 0; k < NUM_COORDS; k++) begin
            ref_corner_ff[k] <= in_corner[k];
         end
      end
   end

   // Snapshot the reference box with the item so a later load cannot disturb it
   always_ff @(posedge clock) begin
      if (ctl.capture_en) begin
         for (int k = 0; k < NUM_COORDS; k++) begin
            ref_box_ff[k]  <= ref_corner_ff[k];
            test_box_ff[k] <= in_corner[k];
         end
         for (int j = 0; j < NUM_AXES; j++) begin
            axis_x_ff[j] <= axis_x_in[j];
            axis_y_ff[j] <= axis_y_in[j];
         end
      end
   end

   assign ref_box  = ref_box_ff;
   assign test_box = test_box_ff;
   assign axis_x   = axis_x_ff;
   assign axis_y   = axis_y_ff;

endmodule

FILE: rtl/bosa_lane.sv
module bosa_lane #(
   parameter int COORD_WIDTH = bosa_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  bosa_pkg::lane_ctl_type        ctl,
   input  logic signed [COORD_WIDTH-1:0] ref_box  [bosa_pkg::NUM_COORDS],
   input  logic signed [COORD_WIDTH-1:0] test_box [bosa_pkg::NUM_COORDS],
   input  logic signed [COORD_WIDTH:0]   axis_x,
   input  logic signed [COORD_WIDTH:0]   axis_y,
   output logic                          lane_hit
);
   import bosa_pkg::*;

   localparam int PW = 2 * COORD_WIDTH + 1;   // one product term
   localparam int JW = 2 * COORD_WIDTH + 2;   // full projection
   localparam int NP = 2 * NUM_CORNERS;       // corners of both boxes

   logic signed [COORD_WIDTH-1:0] cx [NP];
   logic signed [COORD_WIDTH-1:0] cy [NP];
   logic signed [PW-1:0] px_ff   [NP];
   logic signed [PW-1:0] py_ff   [NP];
   logic signed [JW-1:0] proj_ff [NP];
   logic signed [JW-1:0] lo_pair_in [2][2];
   logic signed [JW-1:0] hi_pair_in [2][2];
   logic signed [JW-1:0] lo_pair_ff [2][2];
   logic signed [JW-1:0] hi_pair_ff [2][2];
   logic signed [JW-1:0] min_in [2];
   logic signed [JW-1:0] max_in [2];
   logic signed [JW-1:0] min_ff [2];
   logic signed [JW-1:0] max_ff [2];
   logic                 hit_in;
   logic                 hit_ff;

   // Corners 0..3 from the reference box, 4..7 from the tested quad
   always_comb begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
         cx[k]               = ref_box[2*k];
         cy[k]               = ref_box[2*k+1];
         cx[k + NUM_CORNERS] = test_box[2*k];
         cy[k + NUM_CORNERS] = test_box[2*k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.prod_en) begin
         for (int k = 0; k < NP; k++) begin
            px_ff[k] <= PW'(cx[k]) * PW'(axis_x);
            py_ff[k] <= PW'(cy[k]) * PW'(axis_y);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.proj_en) begin
         for (int k = 0; k < NP; k++) begin
            proj_ff[k] <= JW'(px_ff[k]) + JW'(py_ff[k]);
         end
      end
   end

   // Interval bounds in two compare levels: pairs, then whole box
   always_comb begin
      for (int b = 0; b < 2; b++) begin
         for (int p = 0; p < 2; p++) begin
            if (proj_ff[4*b + 2*p] < proj_ff[4*b + 2*p + 1]) begin
               lo_pair_in[b][p] = proj_ff[4*b + 2*p];
               hi_pair_in[b][p] = proj_ff[4*b + 2*p + 1];
            end else begin
               lo_pair_in[b][p] = proj_ff[4*b + 2*p + 1];
               hi_pair_in[b][p] = proj_ff[4*b + 2*p];
            end
         end
         min_in[b] = (lo_pair_ff[b][1] < lo_pair_ff[b][0]) ? lo_pair_ff[b][1] : lo_pair_ff[b][0];
         max_in[b] = (hi_pair_ff[b][1] > hi_pair_ff[b][0]) ? hi_pair_ff[b][1] : hi_pair_ff[b][0];
      end
      // Touching intervals count as overlap
      hit_in = !((max_ff[0] < min_ff[1]) || (max_ff[1] < min_ff[0]));
   end

   always_ff @(posedge clock) begin
      if (ctl.pair_en) begin
         lo_pair_ff <= lo_pair_in;
         hi_pair_ff <= hi_pair_in;
      end
      if (ctl.span_en) begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
      if (ctl.hit_en) begin
         hit_ff <= hit_in;
      end
   end

   assign lane_hit = hit_ff;

endmodule

FILE: rtl/bosa_merge.sv
module bosa_merge (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               hit_valid,
   input  logic                               lane_hit [bosa_pkg::NUM_AXES],
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bosa_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import bosa_pkg::*;

   logic valid_ff;
   logic overlap_ff;
   logic overlap_in;
   logic load_en;

   // Overlap only when no axis separates the boxes
   always_comb begin
      overlap_in = 1'b1;
      for (int j = 0; j < NUM_AXES; j++) begin
         overlap_in = overlap_in & lane_hit[j];
      end
   end

   assign load_en = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load_en) begin
         valid_ff <= hit_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en && hit_valid) begin
         overlap_ff <= overlap_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-1){1'b0}}, overlap_ff};

endmodule

FILE: verif/box_overlap_checker.sv
`timescale 1ns / 100ps

// Watches both streams of the overlap engine. Keeps its own copy of the
// reference box, predicts the overlap bit of every test at the moment the
// test is taken, and compares each response with the oldest prediction.
module box_overlap_checker #(
   parameter int COORD_WIDTH = bosa_pkg::COORD_WIDTH_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_tvalid,
   input  logic                                        req_tready,
   // corner1_x, corner1_y, ... corner4_x, corner4_y
   input  logic [bosa_pkg::NUM_COORDS*COORD_WIDTH-1:0] req_tdata,
   // func
   input  logic [0:0]                                  req_tuser,
   input  logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // overlap, then zero fill
   input  logic [bosa_pkg::RSP_TDATA_W-1:0]            rsp_tdata,
   output int                                          fail_count,
   output int                                          pending_count,
   output int                                          loads_seen,
   output int                                          tests_seen,
   output int                                          overlaps_seen
);

   typedef logic [bosa_pkg::NUM_COORDS*COORD_WIDTH-1:0] quad_bits_type;

   quad_bits_type reference_box;
   bit            expected_overlaps[$];
   bit            wanted;

   function automatic longint coord(input quad_bits_type q, input int idx);
      return longint'($signed(q[idx*COORD_WIDTH +: COORD_WIDTH]));
   endfunction

   // Interval of the four corners of q along (ax, ay), exact dot products.
   function automatic void project_quad(input quad_bits_type q, input longint ax,
                                        input longint ay, output longint lo,
                                        output longint hi);
      longint p;
      int     k;
      lo = 0;
      hi = 0;
      for (k = 0; k < bosa_pkg::NUM_CORNERS; k++) begin
         p = coord(q, 2*k) * ax + coord(q, 2*k + 1) * ay;
         if (k == 0 || p < lo) lo = p;
         if (k == 0 || p > hi) hi = p;
      end
   endfunction

   // Axes: p1-p2 and p2-p3 of the reference box, then of the tested quad.
   // A zero-length edge gives a zero axis that never separates.
   function automatic bit boxes_overlap(input quad_bits_type a, input quad_bits_type b);
      quad_bits_type owner;
      longint        ax, ay, lo_a, hi_a, lo_b, hi_b;
      int            k, first;
      for (k = 0; k < bosa_pkg::NUM_AXES; k++) begin
         owner = (k < 2) ? a : b;
         first = (k % 2) * 2;
         ax = coord(owner, first) - coord(owner, first + 2);
         ay = coord(owner, first + 1) - coord(owner, first + 3);
         project_quad(a, ax, ay, lo_a, hi_a);
         project_quad(b, ax, ay, lo_b, hi_b);
         if (hi_a < lo_b || hi_b < lo_a) return 1'b0;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         reference_box = '0;
         expected_overlaps.delete();
         fail_count    = 0;
         pending_count = 0;
         loads_seen    = 0;
         tests_seen    = 0;
         overlaps_seen = 0;
      end else begin
         // retire a response before booking a new test
         if (rsp_tvalid && rsp_tready) begin
            if (expected_overlaps.size() == 0) begin
               $display("%0t: response with none expected, actual overlap=%0b",
                        $time, rsp_tdata[0]);
               fail_count++;
            end else begin
               wanted = expected_overlaps.pop_front();
               if (rsp_tdata[0] !== wanted) begin
                  $display("%0t: overlap mismatch, expected %0b, actual %0b",
                           $time, wanted, rsp_tdata[0]);
                  fail_count++;
               end
               if (rsp_tdata[0] === 1'b1) overlaps_seen++;
            end
         end
         if (req_tvalid && req_tready) begin
            if (bosa_pkg::func_type'(req_tuser[0]) == bosa_pkg::FUNC_LOAD) begin
               reference_box = req_tdata;
               loads_seen++;
            end else begin
               expected_overlaps.push_back(boxes_overlap(reference_box, req_tdata));
               tests_seen++;
            end
         end
         pending_count = expected_overlaps.size();
      end
   end

endmodule

FILE: verif/tb_box_overlap_separating_axis.sv
`timescale 1ns / 100ps

module tb_box_overlap_separating_axis;

   import bosa_pkg::*;

   localparam int CW              = COORD_WIDTH_DEF;
   localparam int RANDOM_ITEMS    = 1800;
   localparam int BURST_ITEMS     = 30;
   localparam int HOLD_OFF_CYCLES = 64;
   // responses still drain after the last test; leave some margin
   localparam int DRAIN_CYCLES    = 20;
   // ~1900 transfers, each with random idling on both sides, plus the pipeline,
   // taken many times over
   localparam int CYCLE_LIMIT     = 200000;

   typedef logic [NUM_COORDS*CW-1:0] quad_bits_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   quad_bits_type          req_tdata;   // corner1_x, corner1_y, ... corner4_y
   logic [0:0]             req_tuser;   // func
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // overlap, then zero fill

   int fail_count, pending_count, loads_seen, tests_seen, overlaps_seen;
   int cycle_count = 0;

   bit quiet;          // both sides run with no idle cycles
   bit hold_off_req;   // ask the receiver for one long stall
   int ref_cx, ref_cy; // p1 or rough center of the last well-formed reference box

   box_overlap_separating_axis #(.COORD_WIDTH(CW)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   box_overlap_checker #(.COORD_WIDTH(CW)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .loads_seen    (loads_seen),
      .tests_seen    (tests_seen),
      .overlaps_seen (overlaps_seen)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_box_overlap_separating_axis: FAIL");
         $finish;
      end
   end

   // Pack eight coordinates, corner1_x in the lowest bits.
   function automatic quad_bits_type make_quad(input int x1, input int y1,
                                               input int x2, input int y2,
                                               input int x3, input int y3,
                                               input int x4, input int y4);
      quad_bits_type q;
      int            v[8];
      int            k;
      v = '{x1, y1, x2, y2, x3, y3, x4, y4};
      for (k = 0; k < NUM_COORDS; k++) q[k*CW +: CW] = v[k][CW-1:0];
      return q;
   endfunction

   // Quad p1 = (cx, cy), p2 = p1 + u, p4 = p1 + v, with v the edge u turned a
   // quarter turn and stretched by m/8. Integer rounding keeps it near rectangular.
   function automatic quad_bits_type rect_quad(input int cx, input int cy, input int ux,
                                               input int uy, input int m);
      int vx, vy;
      vx = -(uy * m) / 8;
      vy = (ux * m) / 8;
      return make_quad(cx, cy, cx + ux, cy + uy, cx + ux + vx, cy + uy + vy,
                       cx + vx, cy + vy);
   endfunction

   function automatic int spread(input int r);
      return int'($urandom_range(0, 2 * r)) - r;
   endfunction

   // Offer one transfer after a random gap and hold it until it is taken.
   // A gap lowers tvalid at one falling edge and raises it at a later one.
   task automatic send_quad(input func_type func, input quad_bits_type quad);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 4);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= quad;
      req_tuser  <= func;
      do @(posedge clock); while (!req_tready);
   endtask

   // Extremes, touching and separated boxes, degenerate quads, test before load.
   task automatic run_directed();
      // no load yet: reference box collapsed onto the origin
      send_quad(FUNC_TEST, make_quad(0, 0, 0, 0, 0, 0, 0, 0));
      send_quad(FUNC_TEST, make_quad(16, 16, 32, 16, 32, 32, 16, 32));
      send_quad(FUNC_TEST, make_quad(-16, -16, 16, -16, 16, 16, -16, 16));
      // square of side 20.0 centered on the origin
      send_quad(FUNC_LOAD, make_quad(-160, -160, 160, -160, 160, 160, -160, 160));
      send_quad(FUNC_TEST, make_quad(0, 0, 320, 0, 320, 320, 0, 320));
      // shared edge counts as overlap, one LSB apart does not
      send_quad(FUNC_TEST, make_quad(160, -160, 480, -160, 480, 160, 160, 160));
      send_quad(FUNC_TEST, make_quad(161, -160, 481, -160, 481, 160, 161, 160));
      // diamond touching the right edge with a vertex, then pulled away
      send_quad(FUNC_TEST, make_quad(160, 0, 320, -160, 480, 0, 320, 160));
      send_quad(FUNC_TEST, make_quad(161, 0, 321, -160, 481, 0, 321, 160));
      // diamond beside a corner: only its own diagonal axis separates
      send_quad(FUNC_TEST, make_quad(80, 400, 400, 80, 720, 400, 400, 720));
      // zero-length edges: a point inside and a point outside
      send_quad(FUNC_TEST, make_quad(0, 0, 0, 0, 0, 0, 0, 0));
      send_quad(FUNC_TEST, make_quad(1000, 1000, 1000, 1000, 1000, 1000, 1000, 1000));
      // p1 == p2, while p2-p3 is a real edge
      send_quad(FUNC_TEST, make_quad(100, 100, 100, 100, 300, 300, 300, 300));
      // full-range reference box, tested with corner points and a twisted quad
      send_quad(FUNC_LOAD, make_quad(-32768, -32768, 32767, -32768, 32767, 32767,
                                     -32768, 32767));
      send_quad(FUNC_TEST, make_quad(32767, 32767, 32767, 32767, 32767, 32767,
                                     32767, 32767));
      send_quad(FUNC_TEST, make_quad(-32768, -32768, -32768, -32768, -32768, -32768,
                                     -32768, -32768));
      send_quad(FUNC_TEST, make_quad(-32768, 32767, 32767, -32768, -32768, -32768,
                                     32767, 32767));
      // degenerate reference at one extreme, a full-range test box and a point at another
      send_quad(FUNC_LOAD, make_quad(-32768, 32767, -32768, 32767, -32768, 32767,
                                     -32768, 32767));
      send_quad(FUNC_TEST, make_quad(-32768, -32768, 32767, -32768, 32767, 32767,
                                     -32768, 32767));
      send_quad(FUNC_TEST, make_quad(32767, -32768, 32767, -32768, 32767, -32768,
                                     32767, -32768));
      // load followed at once by a test of the same quad
      send_quad(FUNC_LOAD, make_quad(-500, 200, 300, -400, 900, 400, 100, 1000));
      send_quad(FUNC_TEST, make_quad(-500, 200, 300, -400, 900, 400, 100, 1000));
      ref_cx = 200;
      ref_cy = 300;
   endtask

   // Back-to-back tests while the receiver is held off: the pipeline fills
   // and req_tready must drop until the receiver lets go.
   task automatic run_pressure();
      int k;
      quiet        = 1'b1;
      hold_off_req = 1'b1;
      for (k = 0; k < BURST_ITEMS; k++)
         send_quad(FUNC_TEST, rect_quad(ref_cx + spread(800), ref_cy + spread(800),
                                        spread(400), spread(400),
                                        $urandom_range(1, 16)));
      quiet = 1'b0;
   endtask

   // Mostly boxes built around the current reference so both verdicts occur,
   // some degenerate quads, and a share of raw noise over the full range.
   task automatic run_random(input int count);
      int            k, kind, scale, cx, cy;
      func_type      func;
      quad_bits_type quad;
      for (k = 0; k < count; k++) begin
         // every few hundred items, a stretch with no idling at all
         quiet = (k % 400) < 60;
         kind  = $urandom_range(0, 9);
         func  = ($urandom_range(0, 5) == 0) ? FUNC_LOAD : FUNC_TEST;
         scale = ($urandom_range(0, 7) == 0) ? 2500 : 400;
         if (kind < 2) begin
            quad = {$urandom, $urandom, $urandom, $urandom};
         end else begin
            if (func == FUNC_LOAD) begin
               cx = spread(12000);
               cy = spread(12000);
            end else begin
               cx = ref_cx + spread(3 * scale);
               cy = ref_cy + spread(3 * scale);
            end
            if (kind == 2)
               quad = rect_quad(cx, cy, 0, 0, $urandom_range(0, 16));
            else
               quad = rect_quad(cx, cy, spread(scale), spread(scale),
                                $urandom_range(1, 16));
            if (func == FUNC_LOAD) begin
               ref_cx = cx;
               ref_cy = cy;
            end
         end
         send_quad(func, quad);
      end
   endtask

   // Receiver: a random stall before each response, or one long hold-off
   // when asked, counted here in falling edges.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 4);
         if (hold_off_req) begin
            stall        = HOLD_OFF_CYCLES;
            hold_off_req = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = FUNC_LOAD;
      quiet        = 1'b0;
      hold_off_req = 1'b0;
      ref_cx       = 0;
      ref_cy       = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      run_pressure();
      run_random(RANDOM_ITEMS);
      @(negedge clock);
      req_tvalid <= 1'b0;

      // drain: every booked test answered, then a few quiet cycles
      wait (pending_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d reference loads and %0d box tests (%0d overlapping),",
               loads_seen, tests_seen, overlaps_seen);
      $display("with random idling, no-idle stretches and a %0d-cycle receiver hold-off.",
               HOLD_OFF_CYCLES);
      if (fail_count == 0 && pending_count == 0)
         $display("tb_box_overlap_separating_axis: PASS");
      else
         $display("tb_box_overlap_separating_axis: FAIL");
      $finish;
   end

endmodule
